// ===== rtl/jte_pkg.sv =====
package jte_pkg;

  localparam logic [7:0] ESC_BYTE     = 8'h1b;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0a;
  localparam logic [7:0] DOLLAR_BYTE  = 8'h24;
  localparam logic [7:0] PAREN_BYTE   = 8'h28;
  localparam logic [7:0] B_BYTE       = 8'h42;
  localparam logic [7:0] AT_BYTE      = 8'h40;
  localparam logic [7:0] J_BYTE       = 8'h4a;
  localparam logic [7:0] HIGH_BIT     = 8'h80;
  localparam logic [15:0] EUC_OFFSET  = 16'h8080;
  localparam logic [3:0] DEPTH_MAX    = 4'd15;

  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_SEEN  = 2'd1;
  localparam logic [1:0] ESC_FIRST = 2'd2;

  localparam int unsigned MAX_RES = 3;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    res_cnt_t                    cnt;
    logic [MAX_RES-1:0][7:0]     bytes;
  } res_t;

  function automatic logic [15:0] sjis_to_euc(input logic [7:0] lead, input logic [7:0] trail);
    logic [7:0] row;
    logic [7:0] col;
    row = lead - ((lead >= 8'ha0) ? 8'hc1 : 8'h81);
    row = {row[6:0], 1'b0} + 8'h21;
    if (trail >= 8'h9f) begin
      row = row + 8'h01;
      col = trail - 8'h7e;
    end else begin
      col = trail - ((trail <= 8'h7e) ? 8'h1f : 8'h20);
    end
    return {row, col} + EUC_OFFSET;
  endfunction

endpackage

// ===== rtl/jte_if.sv =====
interface jte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface jte_cfg_if;
  logic valid;
  logic ready;
  logic sjis_mode;
  modport source (output valid, output sjis_mode, input ready);
  modport sink   (input valid, input sjis_mode, output ready);
endinterface

// ===== rtl/japanese_text_to_euc_converter_top.sv =====
// Channel | Dir | Payload                | Request taken when
// in_ch   | in  | in_byte[7:0]           | valid && ready
// out_ch  | out | out_byte[7:0], last_of_run | valid && ready
// cfg_ch  | in  | sjis_mode              | valid && ready (ready held high)
//
// One input byte per cycle, while ready is high, enters a holding register;
// decode runs from there into a three-byte result register drained one byte
// per cycle while out_ch is ready. The first result byte passes the holding
// register, then the result register. Bytes with no result (lead, escape)
// skip the result register; n results occupy it until all n are drained.
// rst_n is synchronous; a stalled out_ch back-pressures in_ch through ready.
module japanese_text_to_euc_converter_top
  import jte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jte_in_if.sink    in_ch,
  jte_out_if.source out_ch,
  jte_cfg_if.sink   cfg_ch
);

  logic sjis_mode_r;
  logic res_valid;
  logic res_ready;
  res_t res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sjis_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      sjis_mode_r <= cfg_ch.sjis_mode;
    end
  end

  jte_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .sjis_mode (sjis_mode_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  jte_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

// ===== rtl/jte_decode.sv =====
module jte_decode
  import jte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       sjis_mode,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] lead_value_r, lead_value_nxt;
  logic [1:0] escape_phase_r, escape_phase_nxt;
  logic [7:0] escape_first_r, escape_first_nxt;
  logic [3:0] shift_depth_r, shift_depth_nxt;
  logic       consume;
  logic [15:0] pair_word;
  logic [7:0] b;

  assign b = hold_byte_r;

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_value_nxt   = lead_value_r;
    escape_phase_nxt = escape_phase_r;
    escape_first_nxt = escape_first_r;
    shift_depth_nxt  = shift_depth_r;
    res.cnt          = '0;
    res.bytes        = '0;
    pair_word        = sjis_mode ? sjis_to_euc(lead_value_r, b) : {lead_value_r, b};
    priority if (escape_phase_r == ESC_SEEN) begin
      escape_first_nxt = b;
      escape_phase_nxt = ESC_FIRST;
    end else if (escape_phase_r != ESC_IDLE) begin
      escape_phase_nxt = ESC_IDLE;
      if (escape_first_r == DOLLAR_BYTE && (b == B_BYTE || b == AT_BYTE)) begin
        if (shift_depth_r != DEPTH_MAX) shift_depth_nxt = shift_depth_r + 4'd1;
      end else if (escape_first_r == PAREN_BYTE && (b == B_BYTE || b == J_BYTE)) begin
        if (shift_depth_r != 4'd0) shift_depth_nxt = shift_depth_r - 4'd1;
      end else begin
        res.cnt   = 2'd3;
        res.bytes = {b, escape_first_r, ESC_BYTE};
      end
    end else if (lead_pending_r) begin
      lead_pending_nxt = 1'b0;
      res.cnt          = 2'd2;
      res.bytes        = {8'h00, pair_word[7:0], pair_word[15:8]};
    end else if (b == NEWLINE_BYTE) begin
      shift_depth_nxt = '0;
      res.cnt         = 2'd1;
      res.bytes[0]    = b;
    end else if (b[7]) begin
      lead_pending_nxt = 1'b1;
      lead_value_nxt   = b;
    end else if (b == ESC_BYTE) begin
      escape_phase_nxt = ESC_SEEN;
    end else begin
      res.cnt      = 2'd1;
      res.bytes[0] = (shift_depth_r != 4'd0) ? (b | HIGH_BIT) : b;
    end
  end

  assign res_valid = hold_valid_r && (res.cnt != 2'd0);
  assign consume   = hold_valid_r && ((res.cnt == 2'd0) || res_ready);
  assign in_ready  = !hold_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r   <= 1'b0;
      lead_pending_r <= 1'b0;
      lead_value_r   <= '0;
      escape_phase_r <= ESC_IDLE;
      escape_first_r <= '0;
      shift_depth_r  <= '0;
    end else begin
      if (in_ready) hold_valid_r <= in_valid;
      if (consume) begin
        lead_pending_r <= lead_pending_nxt;
        lead_value_r   <= lead_value_nxt;
        escape_phase_r <= escape_phase_nxt;
        escape_first_r <= escape_first_nxt;
        shift_depth_r  <= shift_depth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) hold_byte_r <= in_byte;
  end

endmodule

// ===== rtl/jte_serial.sv =====
module jte_serial
  import jte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  output logic       res_ready,
  input  res_t       res,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  res_cnt_t                cnt_r;
  logic [MAX_RES-1:0][7:0] bytes_r;

  assign out_valid   = (cnt_r != 2'd0);
  assign out_byte    = bytes_r[0];
  assign last_of_run = (cnt_r == 2'd1);
  assign res_ready   = (cnt_r == 2'd0) || (out_ready && cnt_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (res_ready && res_valid) begin
      cnt_r <= res.cnt;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      bytes_r <= res.bytes;
    end else if (out_valid && out_ready) begin
      bytes_r <= {8'h00, bytes_r[MAX_RES-1:1]};
    end
  end

endmodule
